// ----- hw/rtl/nibble_rle_raster_expander_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the nibble run-length raster expander
// Next-cycle property forms, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef NIBBLE_RLE_RASTER_EXPANDER_TOP_MACROS_SVH
`define NIBBLE_RLE_RASTER_EXPANDER_TOP_MACROS_SVH

// Check that cons holds in the cycle after ante, outside reset.
`define NRRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("nrre check failed");

// Check that cons holds in the cycle after ante, reset included.
`define NRRE_ASSERT_NEXT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("nrre check failed");

`endif

// ----- hw/rtl/nrre_pkg.sv -----
// ----------------------------------------------------------------------------
// nrre_pkg
// Shared widths, types and constants of the nibble run-length raster expander.
// ----------------------------------------------------------------------------
`default_nettype none

package nrre_pkg;

    localparam int COLUMN_BITS = 12;
    localparam int ROW_BITS    = 11;
    localparam int ADDR_BITS   = COLUMN_BITS + ROW_BITS;
    localparam int RUN_BITS    = 4;
    localparam int VALUE_BITS  = 8;
    localparam int LEFT_BITS   = 15;

    localparam int S_TDATA_BITS = 8;
    localparam int S_TUSER_BITS = 1;
    localparam int M_TDATA_BITS = ((ADDR_BITS + VALUE_BITS + 7) / 8) * 8;
    localparam int M_TUSER_BITS = 2;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 64;

    // Power of two, so the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [COLUMN_BITS-1:0] NUM_COLUMNS_RESET = COLUMN_BITS'(2560);
    localparam logic [ROW_BITS-1:0]    NUM_ROWS_RESET    = ROW_BITS'(1792);

    localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_COLUMNS      = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_ROWS         = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_TABLE_LOW  = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL_TABLE_HIGH = CFG_INDEX_BITS'(3);

    typedef enum logic [1:0] {
        PH_CNT_HI,
        PH_CNT_LO,
        PH_DATA,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [COLUMN_BITS-1:0] num_columns;
        logic [ROW_BITS-1:0]    num_rows;
        logic [63:0]            level_table_low;
        logic [63:0]            level_table_high;
    } cfg_t;

    // One run to emit: start address, pixel count and the per-pixel flags.
    typedef struct packed {
        logic [ADDR_BITS-1:0]  addr;
        logic [RUN_BITS-1:0]   count;
        logic [VALUE_BITS-1:0] value;
        logic                  fin;
        logic                  ovf;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nibble_rle_raster_expander_top.sv -----
// ----------------------------------------------------------------------------
// nibble_rle_raster_expander_top
// Nibble run-length raster expander: encoded bytes in, pixel writes out.
// ----------------------------------------------------------------------------
// Input stream (s_): one encoded byte per transaction in s_tdata; s_tuser
// high marks the first byte of a new image. Each row is a big-endian 16-bit
// byte count followed by data bytes of run length (high nibble) and colour
// index (low nibble).
// Output stream (m_): one pixel write per transaction; m_tlast marks the
// last pixel of one input byte.
// Config channel: cfg_index selects the register (columns, rows, table low,
// table high), cfg_data carries the value; always ready.
// Path: a data byte's run is written into the run queue and then loaded
// into the emitter's registers before its first pixel is offered. The
// parser takes a new byte while the queue is not full; the emitter plays a
// run out at one pixel per cycle (up to 15) while m_tready is high, which
// sets the sustained rate. A four-entry run queue lets the parser run ahead.
// Reset: synchronous, active low; clears parsing state, the queue and the
// output; registers return to 2560 columns, 1792 rows and a zero table.
// Stall: while m_tready is low the current pixel holds; the parser keeps
// taking bytes until the queue is full, then drops s_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_rle_raster_expander_top (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // s_tdata: [7:0] raster_byte
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [nrre_pkg::S_TDATA_BITS-1:0]    s_tdata,
    // s_tuser: [0] frame_start
    input  wire logic [nrre_pkg::S_TUSER_BITS-1:0]    s_tuser,
    // m_tdata: [22:0] pixel_address, [30:23] pixel_value, [31] zero
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [nrre_pkg::M_TDATA_BITS-1:0]         m_tdata,
    // m_tlast: last_of_run
    output logic                                      m_tlast,
    // m_tuser: [0] in_final_row, [1] overflow_seen
    output logic [nrre_pkg::M_TUSER_BITS-1:0]         m_tuser,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [nrre_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [nrre_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import nrre_pkg::*;

    cfg_t cfg_reg;
    logic push, pop, q_valid, q_full;
    cmd_t push_cmd, q_cmd;

    assign cfg_ready = 1'b1;

    // Register file; writes to unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_columns      <= NUM_COLUMNS_RESET;
            cfg_reg.num_rows         <= NUM_ROWS_RESET;
            cfg_reg.level_table_low  <= '0;
            cfg_reg.level_table_high <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_NUM_COLUMNS:      cfg_reg.num_columns      <= cfg_data[COLUMN_BITS-1:0];
                REG_NUM_ROWS:         cfg_reg.num_rows         <= cfg_data[ROW_BITS-1:0];
                REG_LEVEL_TABLE_LOW:  cfg_reg.level_table_low  <= cfg_data;
                REG_LEVEL_TABLE_HIGH: cfg_reg.level_table_high <= cfg_data;
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Parse bytes and turn each data byte into a clipped run.
    nrre_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Hold runs until the emitter is free.
    nrre_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .q_cmd    (q_cmd)
    );

    // Emit one pixel per output transaction.
    nrre_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/nrre_front.sv -----
// ----------------------------------------------------------------------------
// nrre_front
// Byte parser: row counts, run clipping, address and overflow; queues runs.
// ----------------------------------------------------------------------------
`default_nettype none

module nrre_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire nrre_pkg::cfg_t                      cfg,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [nrre_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  wire logic [nrre_pkg::S_TUSER_BITS-1:0]   s_tuser,
    input  wire logic                                q_full,
    output logic                                     push,
    output nrre_pkg::cmd_t                           push_cmd
);
    import nrre_pkg::*;

    phase_t                 phase_reg, phase_next, ph;
    logic [7:0]             hi_reg, hi_next;
    logic [LEFT_BITS-1:0]   left_reg, left_next, left_cur;
    logic [ROW_BITS:0]      row_reg, row_next, row_cur, row_inc;
    logic [COLUMN_BITS-1:0] col_reg, col_next, col_cur, avail;
    logic [ADDR_BITS-1:0]   base_reg, base_next, prod;
    logic                   ovf_reg, ovf_next, ovf_cur;
    logic                   accept;
    logic [15:0]            cnt;
    logic [ROW_BITS-1:0]    diff;
    logic [RUN_BITS-1:0]    run, emit;
    logic [3:0]             idx;
    logic [VALUE_BITS-1:0]  value;
    logic [63:0]            word;
    logic                   fin, clip;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CNT_HI;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg   <= '0;
            left_reg <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            base_reg <= '0;
            ovf_reg  <= 1'b0;
        end else begin
            hi_reg   <= hi_next;
            left_reg <= left_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            base_reg <= base_next;
            ovf_reg  <= ovf_next;
        end
    end

    always_comb begin
        ph       = phase_reg;
        row_cur  = row_reg;
        col_cur  = col_reg;
        left_cur = left_reg;
        ovf_cur  = ovf_reg;
        // New image: clear row tracking before this byte is parsed.
        if (s_tuser[0]) begin
            ph       = PH_CNT_HI;
            row_cur  = '0;
            col_cur  = '0;
            left_cur = '0;
            ovf_cur  = 1'b0;
        end
        if (row_cur >= {1'b0, cfg.num_rows}) begin
            ph = PH_DONE;
        end

        cnt     = {hi_reg, s_tdata};
        diff    = cfg.num_rows - ROW_BITS'(1) - row_cur[ROW_BITS-1:0];
        prod    = ADDR_BITS'(diff) * ADDR_BITS'(cfg.num_columns);
        row_inc = row_cur + (ROW_BITS+1)'(1);

        run   = s_tdata[7:4];
        idx   = s_tdata[3:0];
        word  = idx[3] ? cfg.level_table_high : cfg.level_table_low;
        value = word[{idx[2:0], 3'b000} +: VALUE_BITS];
        fin   = ({1'b0, row_cur} + (ROW_BITS+2)'(1)) == {2'b00, cfg.num_rows};
        avail = (col_cur < cfg.num_columns) ? (cfg.num_columns - col_cur) : '0;
        clip  = COLUMN_BITS'(run) > avail;
        emit  = clip ? avail[RUN_BITS-1:0] : run;

        phase_next = phase_reg;
        hi_next    = hi_reg;
        left_next  = left_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        base_next  = base_reg;
        ovf_next   = ovf_reg;
        push       = 1'b0;
        push_cmd   = '0;

        if (accept) begin
            phase_next = ph;
            left_next  = left_cur;
            row_next   = row_cur;
            col_next   = col_cur;
            ovf_next   = ovf_cur;
            case (ph)
                PH_CNT_HI: begin
                    hi_next    = s_tdata;
                    phase_next = PH_CNT_LO;
                end
                PH_CNT_LO: begin
                    col_next  = '0;
                    base_next = prod;
                    if (cnt[15] || (cnt[15:1] == '0)) begin
                        row_next   = row_inc;
                        left_next  = '0;
                        phase_next = (row_inc >= {1'b0, cfg.num_rows}) ? PH_DONE : PH_CNT_HI;
                    end else begin
                        left_next  = {cnt[14:1], 1'b0};
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (clip) begin
                        ovf_next = 1'b1;
                    end
                    push           = (emit != '0);
                    push_cmd.addr  = base_reg + ADDR_BITS'(col_cur);
                    push_cmd.count = emit;
                    push_cmd.value = value;
                    push_cmd.fin   = fin;
                    push_cmd.ovf   = ovf_cur || clip;
                    col_next       = col_cur + COLUMN_BITS'(emit);
                    left_next      = left_cur - LEFT_BITS'(1);
                    if (left_cur == LEFT_BITS'(1)) begin
                        row_next   = row_inc;
                        col_next   = '0;
                        left_next  = '0;
                        phase_next = (row_inc >= {1'b0, cfg.num_rows}) ? PH_DONE : PH_CNT_HI;
                    end
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/nrre_queue.sv -----
// ----------------------------------------------------------------------------
// nrre_queue
// Short run queue between the byte parser and the pixel emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module nrre_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire nrre_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output logic                q_valid,
    output logic                q_full,
    output nrre_pkg::cmd_t      q_cmd
);
    import nrre_pkg::*;

    cmd_t                 slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] fill_reg;

    assign q_valid = (fill_reg != '0);
    assign q_full  = (fill_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + QCNT_BITS'(1);
                2'b01:   fill_reg <= fill_reg - QCNT_BITS'(1);
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/nrre_back.sv -----
// ----------------------------------------------------------------------------
// nrre_back
// Pixel emitter: plays one queued run out as one pixel per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module nrre_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                q_valid,
    input  wire nrre_pkg::cmd_t                      q_cmd,
    output logic                                     pop,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [nrre_pkg::M_TDATA_BITS-1:0]        m_tdata,
    output logic                                     m_tlast,
    output logic [nrre_pkg::M_TUSER_BITS-1:0]        m_tuser
);
    import nrre_pkg::*;

    logic                  active_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [RUN_BITS-1:0]   left_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  fin_reg, ovf_reg;
    logic                  done;

    assign done     = m_tvalid && m_tready && (left_reg == RUN_BITS'(1));
    assign pop      = q_valid && (!active_reg || done);
    assign m_tvalid = active_reg;
    assign m_tlast  = (left_reg == RUN_BITS'(1));
    assign m_tdata  = M_TDATA_BITS'({value_reg, addr_reg});
    assign m_tuser  = {ovf_reg, fin_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            left_reg   <= '0;
        end else if (pop) begin
            active_reg <= 1'b1;
            left_reg   <= q_cmd.count;
        end else if (m_tvalid && m_tready) begin
            active_reg <= !done;
            left_reg   <= left_reg - RUN_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            addr_reg  <= q_cmd.addr;
            value_reg <= q_cmd.value;
            fin_reg   <= q_cmd.fin;
            ovf_reg   <= q_cmd.ovf;
        end else if (m_tvalid && m_tready) begin
            addr_reg <= addr_reg + ADDR_BITS'(1);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/nrre_checker.sv -----
// ----------------------------------------------------------------------------
// nrre_checker
// Port-level checks of the raster expander's output stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nibble_rle_raster_expander_top_macros.svh"

module nrre_checker (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic [nrre_pkg::M_TDATA_BITS-1:0]    m_tdata,
    input  wire logic                                 m_tlast,
    input  wire logic [nrre_pkg::M_TUSER_BITS-1:0]    m_tuser
);
    import nrre_pkg::*;

    logic                                mid_run;
    logic [ADDR_BITS-1:0]                pix_addr;
    logic [M_TDATA_BITS-ADDR_BITS-1:0]   pix_rest;

    assign mid_run  = m_tvalid && m_tready && !m_tlast;
    assign pix_addr = m_tdata[ADDR_BITS-1:0];
    assign pix_rest = m_tdata[M_TDATA_BITS-1:ADDR_BITS];

    // A stalled pixel holds.
    `NRRE_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Within one run the next pixel follows at once, one address up.
    `NRRE_ASSERT_NEXT(a_run_step, mid_run, m_tvalid && (pix_addr == $past(pix_addr) + ADDR_BITS'(1)))

    // Value and flags stay fixed across one run.
    `NRRE_ASSERT_NEXT(a_run_fixed, mid_run, (m_tuser == $past(m_tuser)) && (pix_rest == $past(pix_rest)))

    // Nothing is offered right after reset.
    `NRRE_ASSERT_NEXT_ALWAYS(a_reset_idle, !aresetn, !m_tvalid)

endmodule

bind nibble_rle_raster_expander_top nrre_checker u_nrre_checker (.*);

`default_nettype wire
